// ===== hdl/urxfb_pkg.sv =====
`default_nettype none

package urxfb_pkg;

  // Fixed field widths
  localparam int PERIOD_W  = 16;
  localparam int ELAPSED_W = 12;
  localparam int BYTE_W    = 8;

  // Sample counter and sample points saturate here
  localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

  // Defaults for the top-level parameters
  localparam int FRAC_BITS_DEF      = 8;
  localparam int DATA_BITS_DEF      = 8;
  localparam int DEFAULT_PERIOD_DEF = 16;

  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              stop_ok;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/urxfb_in_if.sv =====
`default_nettype none

interface urxfb_in_if;
  logic valid;
  logic ready;
  logic line_sample;

  modport source (output valid, output line_sample, input ready);
  modport sink (input valid, input line_sample, output ready);
endinterface

`default_nettype wire

// ===== hdl/urxfb_out_if.sv =====
`default_nettype none

interface urxfb_out_if;
  logic                           valid;
  logic                           ready;
  logic [urxfb_pkg::BYTE_W-1:0]   data_byte;
  logic                           stop_ok;

  modport source (output valid, output data_byte, output stop_ok, input ready);
  modport sink (input valid, input data_byte, input stop_ok, output ready);
endinterface

`default_nettype wire

// ===== hdl/uart_receiver_fractional_bit_period_top.sv =====
// UART receiver with fractional bit period and mid-bit sampling.
// sample channel: one oversampled line level per word (1 idle, 0 low).
// frame channel: one word per frame, data_byte (LSB first) and stop_ok.
// cfg_wr_en / cfg_wr_data: writes bit_period, samples per bit with
//   FRAC_BITS fraction bits; the sample-point table is rebuilt in the
//   same edge, so a sample word may follow in the very next cycle.
// Timing: one sample word per cycle sustained. Each word is fully handled
//   in the cycle it is accepted; every sample point that falls on it
//   (several can coincide at short periods) is resolved at once.
// Latency: the frame word is valid the cycle after the stop sample is taken.
// Stall: the frame word sits in an output register; sample words keep
//   flowing while it is free or being taken, and sample.ready drops only
//   while a finished frame waits on a stalled frame.ready.
// Reset (synchronous, rst high): hunting for a start edge, no frame word
//   pending, bit_period back to DEFAULT_PERIOD << FRAC_BITS.
// A low stop sample still yields a frame word with stop_ok low; hunting
//   resumes with the next sample.
`default_nettype none

module uart_receiver_fractional_bit_period_top #(
  parameter int FRAC_BITS      = urxfb_pkg::FRAC_BITS_DEF,
  parameter int DATA_BITS      = urxfb_pkg::DATA_BITS_DEF,
  parameter int DEFAULT_PERIOD = urxfb_pkg::DEFAULT_PERIOD_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [urxfb_pkg::PERIOD_W-1:0] cfg_wr_data,
  urxfb_in_if.sink                       sample,
  urxfb_out_if.source                    frame
);

  // sample points for bits 1 .. DATA_BITS+1, from the current period
  logic [urxfb_pkg::ELAPSED_W-1:0] points [DATA_BITS+1];
  urxfb_pkg::result_t              out_word;

  urxfb_points #(
    .FRAC_BITS      (FRAC_BITS),
    .DATA_BITS      (DATA_BITS),
    .DEFAULT_PERIOD (DEFAULT_PERIOD)
  ) u_points (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .points      (points)
  );

  urxfb_core #(
    .DATA_BITS (DATA_BITS)
  ) u_core (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (sample.valid),
    .in_ready    (sample.ready),
    .line_sample (sample.line_sample),
    .points      (points),
    .out_valid   (frame.valid),
    .out_ready   (frame.ready),
    .out_word    (out_word)
  );

  // unpack the held frame word onto the channel
  assign frame.data_byte = out_word.data_byte;
  assign frame.stop_ok   = out_word.stop_ok;

endmodule

`default_nettype wire

// ===== hdl/urxfb_points.sv =====
`default_nettype none

// Sample-point table: point k = round((k + 0.5) * period), k = 1 .. DATA_BITS+1,
// worked out once whenever a new period is written on cfg_wr_data (or at reset).
module urxfb_points #(
  parameter int FRAC_BITS      = urxfb_pkg::FRAC_BITS_DEF,
  parameter int DATA_BITS      = urxfb_pkg::DATA_BITS_DEF,
  parameter int DEFAULT_PERIOD = urxfb_pkg::DEFAULT_PERIOD_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_wr_en,
  input  logic [urxfb_pkg::PERIOD_W-1:0]    cfg_wr_data,
  output logic [urxfb_pkg::ELAPSED_W-1:0]   points [DATA_BITS+1]
);

  // period * (2k+1) needs at most 5 extra bits, one more for the rounding add
  localparam int NUM_W = urxfb_pkg::PERIOD_W + 6;
  localparam logic [urxfb_pkg::PERIOD_W-1:0] RESET_PERIOD =
    urxfb_pkg::PERIOD_W'(DEFAULT_PERIOD << FRAC_BITS);

  logic [urxfb_pkg::PERIOD_W-1:0]  src;
  logic [NUM_W-1:0]                num [DATA_BITS+1];
  logic [NUM_W-1:0]                quo [DATA_BITS+1];
  logic [urxfb_pkg::ELAPSED_W-1:0] points_next [DATA_BITS+1];

  always_comb begin
    src = rst ? RESET_PERIOD : cfg_wr_data;
    for (int i = 0; i <= DATA_BITS; i++) begin
      // constant odd multiplier: a couple of shift-adds
      num[i] = NUM_W'(src) * NUM_W'(2 * i + 3) + NUM_W'(1 << FRAC_BITS);
      quo[i] = num[i] >> (FRAC_BITS + 1);
      points_next[i] = (quo[i] > NUM_W'(urxfb_pkg::ELAPSED_MAX)) ?
                       urxfb_pkg::ELAPSED_MAX : urxfb_pkg::ELAPSED_W'(quo[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_wr_en) begin
      points <= points_next;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/urxfb_core.sv =====
`default_nettype none

// Frame tracker: one sample per accepted word, all coinciding sample points
// resolved in the same cycle, result held in an output register.
module urxfb_core #(
  parameter int DATA_BITS = urxfb_pkg::DATA_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             line_sample,
  input  logic [urxfb_pkg::ELAPSED_W-1:0]  points [DATA_BITS+1],
  output logic                             out_valid,
  input  logic                             out_ready,
  output urxfb_pkg::result_t               out_word
);

  localparam int POS_W = $clog2(DATA_BITS + 1);
  localparam int OUT_N = (DATA_BITS < urxfb_pkg::BYTE_W) ? DATA_BITS : urxfb_pkg::BYTE_W;

  logic                            busy;
  logic [urxfb_pkg::ELAPSED_W-1:0] elapsed;
  logic [urxfb_pkg::ELAPSED_W-1:0] next_point;
  logic [POS_W-1:0]                bit_pos;
  logic [DATA_BITS-1:0]            shift_data;

  logic                            accept;
  logic                            active;
  logic                            run;
  logic                            done;
  logic [DATA_BITS:0]              take;
  logic [urxfb_pkg::ELAPSED_W-1:0] elapsed_next;
  logic [urxfb_pkg::ELAPSED_W-1:0] first_pt;
  logic [urxfb_pkg::ELAPSED_W-1:0] pt;
  logic [urxfb_pkg::ELAPSED_W-1:0] next_point_next;
  logic [POS_W-1:0]                pos0;
  logic [POS_W-1:0]                bit_pos_next;
  logic [DATA_BITS-1:0]            shift0;
  logic [DATA_BITS-1:0]            shift_data_next;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    // first low sample while hunting is offset 0
    active = busy || !line_sample;
    if (!busy) begin
      elapsed_next = '0;
    end else if (elapsed == urxfb_pkg::ELAPSED_MAX) begin
      elapsed_next = elapsed;
    end else begin
      elapsed_next = elapsed + 1'b1;
    end
    pos0     = busy ? bit_pos : '0;
    shift0   = busy ? shift_data : '0;
    first_pt = busy ? next_point : points[0];

    // walk the points from the current bit; stop at the first not reached
    run          = active;
    take         = '0;
    pt           = first_pt;
    bit_pos_next = pos0;
    for (int j = 0; j <= DATA_BITS; j++) begin
      if (POS_W'(j) >= pos0) begin
        pt      = (POS_W'(j) == pos0) ? first_pt : points[j];
        run     = run && (elapsed_next >= pt);
        take[j] = run;
        if (run && j < DATA_BITS) begin
          bit_pos_next = POS_W'(j + 1);
        end
      end
    end
    done = take[DATA_BITS];

    for (int j = 0; j < DATA_BITS; j++) begin
      shift_data_next[j] = take[j] ? line_sample : shift0[j];
    end

    next_point_next = (bit_pos_next != pos0) ? points[bit_pos_next] : first_pt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      elapsed    <= '0;
      next_point <= '0;
      bit_pos    <= '0;
      shift_data <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (accept && done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept && done) begin
        busy       <= 1'b0;
        elapsed    <= '0;
        next_point <= '0;
        bit_pos    <= '0;
        shift_data <= shift_data_next;
      end else if (accept && active) begin
        busy       <= 1'b1;
        elapsed    <= elapsed_next;
        next_point <= next_point_next;
        bit_pos    <= bit_pos_next;
        shift_data <= shift_data_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && done) begin
      out_word.data_byte <= urxfb_pkg::BYTE_W'(shift_data_next[OUT_N-1:0]);
      out_word.stop_ok   <= line_sample;
    end
  end

  // a stop sample always ends the frame
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> !busy && out_valid)
    else $error("frame did not close on stop sample");

  // while hunting the counters sit at zero
  a_hunt_clear: assert property (@(posedge clk) disable iff (rst)
    !busy |-> elapsed == '0 && bit_pos == '0)
    else $error("counters not cleared while hunting");

  // bit position stays within the frame
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    busy |-> bit_pos <= POS_W'(DATA_BITS))
    else $error("bit position beyond stop bit");

  // sample counter advances by one per word inside a frame until it saturates
  a_elapsed_step: assert property (@(posedge clk) disable iff (rst)
    accept && busy && !done && elapsed != urxfb_pkg::ELAPSED_MAX
    |=> elapsed == $past(elapsed) + 1'b1)
    else $error("sample counter skipped");

endmodule

`default_nettype wire
